FILE: sv/xrr_pkg.sv
// Shared constants and types for the xorshift range generator.
`default_nettype none
package xrr_pkg;

    // Item and state widths
    localparam int WORD_W = 64;
    localparam int RES_W  = 63;

    // Generator reset values
    localparam logic [WORD_W-1:0] INIT_A     = 64'd123456789;
    localparam logic [WORD_W-1:0] INIT_B     = 64'd362436069;
    localparam logic [WORD_W-1:0] INIT_C     = 64'd521288629;
    localparam logic [WORD_W-1:0] SEED_RESET = 64'd88675123;

    // Xorshift shift amounts
    localparam int SHIFT_LEFT = 11;
    localparam int SHIFT_D    = 19;
    localparam int SHIFT_T    = 8;

    // Radix-2 divider: one quotient bit per cycle
    localparam int DIV_STEPS = WORD_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    // Commands from the controller to the datapath
    typedef struct packed {
        logic start;     // advance generator, load divider operands
        logic div_step;  // one restoring division step
        logic load_out;  // capture remainder into the output register
    } xrr_cmd_t;

endpackage
`default_nettype wire

FILE: sv/xrr_in_if.sv
// Input channel: valid/ready handshake carrying the range limit.
`default_nettype none
interface xrr_in_if;
    logic                              valid;
    logic                              ready;
    logic signed [xrr_pkg::WORD_W-1:0] range_limit;

    modport source (output valid, output range_limit, input ready);
    modport sink   (input valid, input range_limit, output ready);
endinterface
`default_nettype wire

FILE: sv/xrr_out_if.sv
// Output channel: valid/ready handshake carrying the random value.
`default_nettype none
interface xrr_out_if;
    logic                       valid;
    logic                       ready;
    logic [xrr_pkg::RES_W-1:0]  random_value;

    modport source (output valid, output random_value, input ready);
    modport sink   (input valid, input random_value, output ready);
endinterface
`default_nettype wire

FILE: sv/xrr_ctrl.sv
// Controller: sequences generator update, division steps and output load.
`default_nettype none
module xrr_ctrl
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output      logic              in_ready,
    output      logic              out_valid,
    input  wire logic              out_ready,
    output      xrr_pkg::xrr_cmd_t cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    logic [1:0]                 state_reg, state_next;
    logic [xrr_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic                       out_valid_reg, out_valid_next;
    logic                       out_free;

    // Output register is free when empty or being drained this cycle
    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.start  = 1'b1;
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == xrr_pkg::CNT_W'(xrr_pkg::DIV_STEPS - 1))
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output valid flag
    always_comb
    begin
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
`default_nettype wire

FILE: sv/xrr_datapath.sv
// Datapath: xorshift word state, magnitude logic, restoring divider, output register.
`default_nettype none
module xrr_datapath
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire xrr_pkg::xrr_cmd_t                 cmd,
    input  wire logic                              seed_we,
    input  wire logic [xrr_pkg::WORD_W-1:0]        seed_wdata,
    input  wire logic signed [xrr_pkg::WORD_W-1:0] range_limit,
    output      logic [xrr_pkg::RES_W-1:0]         random_value
);

    localparam int W = xrr_pkg::WORD_W;

    logic [W-1:0] word_a_reg, word_b_reg, word_c_reg, word_d_reg;
    logic [W-1:0] rem_reg, rem_next;
    logic [W-1:0] dvd_reg, dvd_next;
    logic [W-1:0] dvs_reg, dvs_next;
    logic [xrr_pkg::RES_W-1:0] res_reg;

    logic [W-1:0] t_val, d_sra, new_d, d_mag, lim_mag;
    logic [W:0]   shifted, diff;

    // Xorshift update of the fourth word
    assign t_val = word_a_reg ^ (word_a_reg << xrr_pkg::SHIFT_LEFT);
    assign d_sra = {{xrr_pkg::SHIFT_D{word_d_reg[W-1]}}, word_d_reg[W-1:xrr_pkg::SHIFT_D]};
    assign new_d = word_d_reg ^ d_sra ^ t_val ^ (t_val >> xrr_pkg::SHIFT_T);

    // Unsigned magnitudes; zero limit counts as one
    assign d_mag   = new_d[W-1] ? (~new_d + 1'b1) : new_d;
    assign lim_mag = range_limit[W-1] ? (~range_limit + 1'b1) : range_limit;

    // Restoring division step: shift in next dividend bit, subtract if it fits
    assign shifted = {rem_reg, dvd_reg[W-1]};
    assign diff    = shifted - {1'b0, dvs_reg};

    always_comb
    begin
        rem_next = rem_reg;
        dvd_next = dvd_reg;
        dvs_next = dvs_reg;
        if (cmd.start)
        begin
            rem_next = '0;
            dvd_next = d_mag;
            dvs_next = (lim_mag == '0) ? W'(1) : lim_mag;
        end
        else if (cmd.div_step)
        begin
            rem_next = diff[W] ? shifted[W-1:0] : diff[W-1:0];
            dvd_next = {dvd_reg[W-2:0], 1'b0};
        end
    end

    // Generator words; a seed write reloads the fourth word unless start advances them
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_a_reg <= xrr_pkg::INIT_A;
            word_b_reg <= xrr_pkg::INIT_B;
            word_c_reg <= xrr_pkg::INIT_C;
            word_d_reg <= xrr_pkg::SEED_RESET;
        end
        else if (cmd.start)
        begin
            word_a_reg <= word_b_reg;
            word_b_reg <= word_c_reg;
            word_c_reg <= word_d_reg;
            word_d_reg <= new_d;
        end
        else if (seed_we)
        begin
            word_d_reg <= seed_wdata;
        end
    end

    // Divider and output payload registers
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        if (cmd.load_out)
        begin
            res_reg <= rem_reg[xrr_pkg::RES_W-1:0];
        end
    end

    assign random_value = res_reg;

endmodule
`default_nettype wire

FILE: sv/xorshift_range_random.sv
// An accepted item runs the radix-2 divider one bit per cycle, then loads its remainder
// into the output register; the input stays blocked until that load.
// The next item is accepted while a finished result waits in the output register.
// Reset (rst_n, async active low): words return to their initial values, the fourth
// word to 88675123; the output is empty. A seed write reloads it unless an item starts.
`default_nettype none
module xorshift_range_random
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_wr_en,
    input  wire logic [xrr_pkg::WORD_W-1:0]   cfg_wr_data,
    xrr_in_if.sink                            in_ch,
    xrr_out_if.source                         out_ch
);

    xrr_pkg::xrr_cmd_t cmd;

    // Sequencer
    xrr_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .cmd       (cmd)
    );

    // Generator and divider
    xrr_datapath u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .seed_we      (cfg_wr_en),
        .seed_wdata   (cfg_wr_data),
        .range_limit  (in_ch.range_limit),
        .random_value (out_ch.random_value)
    );

    // Commands are mutually exclusive
    a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cmd))
        else $error("controller issued overlapping commands");

    // A new result never overwrites one that is still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_ch.valid || out_ch.ready))
        else $error("output register overwritten while stalled");

    // An accepted item blocks the input until its division is done
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready) |=> (!in_ch.ready && cmd.div_step))
        else $error("input not blocked after accept");

    // Results appear only after a full division, possibly held by a stalled output
    a_load_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(cmd.load_out) |->
            ($past(cmd.div_step) || $past(out_ch.valid && !out_ch.ready)))
        else $error("result loaded without preceding division");

endmodule
`default_nettype wire
